FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers shared by the RTL; empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/core/tslc_pkg.sv
// ----------------------------------------------------------------------------
// tslc_pkg
// Shared constants for the tile slot lru cache
// ----------------------------------------------------------------------------
package tslc_pkg;

    // default build parameters
    localparam int SLOTS_DEF      = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed field widths
    localparam int RING_W  = 3;
    localparam int FRAME_W = 32;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;

    // configuration registers
    localparam int          APB_ADDR_W       = 3;
    localparam logic        REG_SLOT_COUNT   = 1'b0;
    localparam logic [6:0]  SLOT_COUNT_RESET = 7'd64;

    // request kinds
    localparam logic REQ_TOUCH = 1'b0;
    localparam logic REQ_FILL  = 1'b1;

endpackage

FILE: rtl/core/tile_slot_lru_cache_top.sv
// ----------------------------------------------------------------------------
// tile_slot_lru_cache_top
// Residency table of tile slots with oldest-stamp replacement
// ----------------------------------------------------------------------------
// Flow: an accepted item is scanned over L slots in ST_SCAN, then ST_FINISH loads the output register once it is free;
// L = min(active slots, filled slots); one slot table read per cycle sets the scan length.
// A new item is taken only in ST_IDLE, once the previous item has left ST_FINISH.
// The result sits in an output register, so the next item is taken while it waits.
// Reset: async active low; slot_count returns to 64, fill count to zero, table contents
// are left as they are and only filled slots are ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tile_slot_lru_cache_top
    import tslc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int IN_W  = ((RING_W + 2 * COORD_BITS + FRAME_W + 7) / 8) * 8,
    localparam int OUT_W = ((SLOT_W + RING_W + 2 * COORD_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_W-1:0]       s_tdata,   // tile_ring, tile_x, tile_z, frame, zero pad
    input  logic                  s_tuser,   // req_type
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // slot, evicted_ring, evicted_x, evicted_z, pad
    output logic [2:0]            m_tuser    // hit, allocated, evicted
);

    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int ENT_W = RING_W + 2 * COORD_BITS + FRAME_W;
    localparam int X_LSB = RING_W;
    localparam int Z_LSB = RING_W + COORD_BITS;
    localparam int F_LSB = RING_W + 2 * COORD_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // control and config
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] slot_count_reg;
    logic [CW-1:0]    next_unused_reg;
    logic [CW-1:0]    act_n;
    logic [CW-1:0]    act_n_reg;
    logic [CW-1:0]    lim_reg;
    logic [CW-1:0]    issue_reg;
    logic             pend_reg;
    logic [IW-1:0]    pidx_reg;

    // request hold
    logic                  req_type_reg;
    logic [RING_W-1:0]     req_ring_reg;
    coord_t                req_x_reg;
    coord_t                req_z_reg;
    logic [FRAME_W-1:0]    req_frame_reg;

    // scan results
    logic                  found_reg;
    logic [IW-1:0]         found_idx_reg;
    logic [IW-1:0]         best_idx_reg;
    logic [FRAME_W-1:0]    best_stamp_reg;
    logic [RING_W-1:0]     best_ring_reg;
    coord_t                best_x_reg;
    coord_t                best_z_reg;

    // slot table
    logic [ENT_W-1:0]      mem [SLOTS];
    logic [ENT_W-1:0]      mem_q;
    logic                  rd_en;
    logic [IW-1:0]         rd_addr;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [ENT_W-1:0]      wr_data;

    // table entry fields
    logic [RING_W-1:0]     q_ring;
    coord_t                q_x;
    coord_t                q_z;
    logic [FRAME_W-1:0]    q_stamp;
    logic                  q_match;

    // finish decisions
    logic                  out_free;
    logic                  do_finish;
    logic                  fill_miss;
    logic                  take_unused;
    logic [IW-1:0]         target;
    logic [31:0]           slot_wide;

    // output registers
    logic                  m_tvalid_reg;
    logic [SLOT_W-1:0]     o_slot_reg;
    logic                  o_hit_reg;
    logic                  o_alloc_reg;
    logic                  o_evict_reg;
    logic [RING_W-1:0]     o_ring_reg;
    coord_t                o_x_reg;
    coord_t                o_z_reg;

    logic                  in_acc;
    logic                  cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        if (paddr[2] == REG_SLOT_COUNT)
        begin
            prdata = {{(32 - CNT_W){1'b0}}, slot_count_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_SLOT_COUNT))
        begin
            slot_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // effective slot count clamped to 1..SLOTS
    always_comb
    begin
        if (slot_count_reg == '0)
        begin
            act_n = CW'(1);
        end
        else if (32'(slot_count_reg) > SLOTS)
        begin
            act_n = CW'(SLOTS);
        end
        else
        begin
            act_n = CW'(slot_count_reg);
        end
    end

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // table entry unpack
    assign q_ring  = mem_q[RING_W-1:0];
    assign q_x     = mem_q[X_LSB +: COORD_BITS];
    assign q_z     = mem_q[Z_LSB +: COORD_BITS];
    assign q_stamp = mem_q[F_LSB +: FRAME_W];
    assign q_match = (q_ring == req_ring_reg) && (q_x == req_x_reg) && (q_z == req_z_reg);

    // read issue during the scan
    assign rd_en   = (state_reg == ST_SCAN) && (issue_reg < lim_reg);
    assign rd_addr = issue_reg[IW-1:0];

    // finish decisions
    assign do_finish   = (state_reg == ST_FINISH) && out_free;
    assign fill_miss   = !found_reg && (req_type_reg == REQ_FILL);
    assign take_unused = next_unused_reg < act_n_reg;
    assign target      = take_unused ? next_unused_reg[IW-1:0] : best_idx_reg;
    assign wr_en       = do_finish &&
                         ((found_reg && (req_type_reg == REQ_TOUCH)) || fill_miss);
    assign wr_addr     = found_reg ? found_idx_reg : target;
    assign wr_data     = {req_frame_reg, req_z_reg, req_x_reg, req_ring_reg};

    // slot table memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // state sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!rd_en && !pend_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            next_unused_reg <= '0;
            issue_reg       <= '0;
            pend_reg        <= 1'b0;
            found_reg       <= 1'b0;
            lim_reg         <= '0;
            act_n_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= rd_en;
            if (in_acc)
            begin
                act_n_reg <= act_n;
                lim_reg   <= (next_unused_reg < act_n) ? next_unused_reg : act_n;
                issue_reg <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (rd_en)
                begin
                    issue_reg <= issue_reg + CW'(1);
                end
                if (pend_reg && q_match && !found_reg)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (do_finish && fill_miss && take_unused)
            begin
                next_unused_reg <= next_unused_reg + CW'(1);
            end
        end
    end

    // request hold and scan datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            req_type_reg  <= s_tuser;
            req_ring_reg  <= s_tdata[RING_W-1:0];
            req_x_reg     <= s_tdata[X_LSB +: COORD_BITS];
            req_z_reg     <= s_tdata[Z_LSB +: COORD_BITS];
            req_frame_reg <= s_tdata[F_LSB +: FRAME_W];
        end
        if (rd_en)
        begin
            pidx_reg <= rd_addr;
        end
        // first match wins
        if (pend_reg && q_match && !found_reg)
        begin
            found_idx_reg <= pidx_reg;
        end
        // oldest stamp, lowest index on ties
        if (pend_reg && ((pidx_reg == '0) || (q_stamp < best_stamp_reg)))
        begin
            best_idx_reg   <= pidx_reg;
            best_stamp_reg <= q_stamp;
            best_ring_reg  <= q_ring;
            best_x_reg     <= q_x;
            best_z_reg     <= q_z;
        end
    end

    // result assembly
    always_comb
    begin
        slot_wide = '0;
        if (found_reg)
        begin
            slot_wide[IW-1:0] = found_idx_reg;
        end
        else if (req_type_reg == REQ_FILL)
        begin
            slot_wide[IW-1:0] = target;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (do_finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_finish)
        begin
            o_hit_reg   <= found_reg;
            o_slot_reg  <= slot_wide[SLOT_W-1:0];
            o_alloc_reg <= fill_miss;
            o_evict_reg <= fill_miss && !take_unused;
            if (fill_miss && !take_unused)
            begin
                o_ring_reg <= best_ring_reg;
                o_x_reg    <= best_x_reg;
                o_z_reg    <= best_z_reg;
            end
            else
            begin
                o_ring_reg <= '0;
                o_x_reg    <= '0;
                o_z_reg    <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {o_evict_reg, o_alloc_reg, o_hit_reg};
    assign m_tdata  = {{(OUT_W - SLOT_W - RING_W - 2 * COORD_BITS){1'b0}},
                       o_z_reg, o_x_reg, o_ring_reg, o_slot_reg};

    // checks
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, 32'(next_unused_reg) <= SLOTS, "fill count past capacity")
    `ASSERT_ALWAYS(a_issue_bound, clk, rst_n, issue_reg <= lim_reg, "scan ran past its limit")
    `ASSERT_NEXT(a_accept_scan, clk, rst_n, in_acc, state_reg == ST_SCAN, "accept did not start scan")
    `ASSERT_IMPL(a_evict_alloc, clk, rst_n, m_tvalid && m_tuser[2], m_tuser[1] && !m_tuser[0], "eviction without allocation")
    `ASSERT_IMPL(a_hit_noalloc, clk, rst_n, m_tvalid && m_tuser[0], !m_tuser[1], "hit also allocated")

endmodule

FILE: bench/tile_slot_lru_cache_top_tb.sv
// ----------------------------------------------------------------------------
// tile_slot_lru_cache_top_tb
// Self-checking bench for the tile slot cache: a stream driver with bursts and
// gaps, a stalling result sink, and an in-bench table model that predicts hit,
// install and oldest-stamp eviction for every accepted item
// ----------------------------------------------------------------------------
module tile_slot_lru_cache_top_tb;
    import tslc_pkg::*;

    localparam int SLOTS      = SLOTS_DEF;
    localparam int COORD_W    = COORD_BITS_DEF;
    localparam int IN_W       = ((RING_W + 2 * COORD_W + FRAME_W + 7) / 8) * 8;
    localparam int OUT_W      = ((SLOT_W + RING_W + 2 * COORD_W + 7) / 8) * 8;
    localparam int LIMIT      = 1000000;
    localparam int DRAIN_WAIT = 80;
    localparam logic [31:0] FRAME_MAX = 32'hFFFF_FFFE;
    localparam logic [APB_ADDR_W-1:0] SLOT_COUNT_ADDR =
        APB_ADDR_W'(4 * int'(REG_SLOT_COUNT));

    typedef struct packed {
        logic [RING_W-1:0]         ring;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] z;
    } tile_coord_t;

    typedef struct packed {
        logic               req_type;
        tile_coord_t        coord;
        logic [FRAME_W-1:0] frame;
    } tile_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              allocated;
        logic              evicted;
        tile_coord_t       ev;
    } tile_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [2:0]        m_tuser;

    // table model state
    bit                tbl_valid [SLOTS];
    tile_coord_t       tbl_coord [SLOTS];
    logic [FRAME_W-1:0] tbl_stamp [SLOTS];
    int                tbl_next_free = 0;
    logic [CNT_W-1:0]  cfg_slot_count = SLOT_COUNT_RESET;

    // stimulus and scoreboard
    tile_req_t         req_q [$];
    tile_result_t      lookup_q [$];
    tile_coord_t       tile_pool [$];
    logic [FRAME_W-1:0] frame_now = '0;
    int                n_queued = 0;
    int                n_accepted = 0;
    int                n_results = 0;
    int                mismatches = 0;
    int                n_hits = 0;
    int                n_installs = 0;
    int                n_evictions = 0;
    int                n_settings = 0;
    int                cycles = 0;
    logic              req_fire = 1'b0;

    // sender and receiver pacing
    int                gap_left = 0;
    int                burst_left = 1;
    bit                gaps_on = 1'b1;
    int                ready_mode = 0;
    logic [15:0]       ready_pat = 16'hFFFF;

    tile_slot_lru_cache_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input int idx, input string what,
                                   input logic [31:0] got, input logic [31:0] want);
        mismatches++;
        $display("result %0d: %s got %0h expected %0h", idx, what, got, want);
    endtask

    // lookup, refresh, install and oldest-stamp eviction over the active slots
    function automatic tile_result_t resolve_request(input tile_req_t rq);
        tile_result_t res;
        int n;
        int i;
        int found;
        int target;
        res = '0;
        n = (cfg_slot_count == 0) ? 1 : (cfg_slot_count > SLOTS) ? SLOTS : cfg_slot_count;
        found = -1;
        for (i = 0; i < n; i++)
            if (found < 0 && tbl_valid[i] && tbl_coord[i] == rq.coord)
                found = i;
        if (found >= 0)
        begin
            res.hit = 1'b1;
            res.slot = found[SLOT_W-1:0];
            if (rq.req_type == REQ_TOUCH)
                tbl_stamp[found] = rq.frame;
        end
        else if (rq.req_type == REQ_FILL)
        begin
            if (tbl_next_free < n)
            begin
                target = tbl_next_free;
                tbl_next_free++;
            end
            else
            begin
                target = 0;
                for (i = 1; i < n; i++)
                    if (tbl_stamp[i] < tbl_stamp[target])
                        target = i;
                if (tbl_valid[target])
                begin
                    res.evicted = 1'b1;
                    res.ev = tbl_coord[target];
                end
            end
            tbl_valid[target] = 1'b1;
            tbl_coord[target] = rq.coord;
            tbl_stamp[target] = rq.frame;
            res.slot = target[SLOT_W-1:0];
            res.allocated = 1'b1;
        end
        return res;
    endfunction

    // driver: bursts with random gaps, receiver stall pattern
    always @(negedge clk)
    begin
        tile_req_t rq;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || req_fire)
            begin
                if (gap_left != 0)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (req_q.size() != 0)
                begin
                    rq = req_q[0];
                    req_q.delete(0);
                    s_tdata <= {{(IN_W - RING_W - 2 * COORD_W - FRAME_W){1'b0}},
                                rq.frame, rq.coord.z, rq.coord.x, rq.coord.ring};
                    s_tuser <= rq.req_type;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 16);
                        gap_left <= (gaps_on && $urandom_range(0, 9) > 2) ?
                                    $urandom_range(1, 80) : 0;
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_tvalid <= 1'b0;
            end
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ready_pat[15];
                2: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
            ready_pat <= {ready_pat[14:0], ready_pat[15]};
        end
    end

    // monitor: predict on accept, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        tile_req_t rq;
        tile_result_t want;
        tile_result_t got;
        if (!rst_n)
            req_fire <= 1'b0;
        else
        begin
            req_fire <= s_tvalid && (s_tready === 1'b1);
            if (s_tvalid && s_tready === 1'b1)
            begin
                rq.req_type = s_tuser;
                rq.coord.ring = s_tdata[2:0];
                rq.coord.x = s_tdata[18:3];
                rq.coord.z = s_tdata[34:19];
                rq.frame = s_tdata[66:35];
                want = resolve_request(rq);
                n_hits += want.hit;
                n_installs += want.allocated;
                n_evictions += want.evicted;
                lookup_q.insert(lookup_q.size(), want);
                n_accepted <= n_accepted + 1;
            end
            if (m_tvalid === 1'b1 && m_tready)
            begin
                got.hit = m_tuser[0];
                got.allocated = m_tuser[1];
                got.evicted = m_tuser[2];
                got.slot = m_tdata[5:0];
                got.ev.ring = m_tdata[8:6];
                got.ev.x = m_tdata[24:9];
                got.ev.z = m_tdata[40:25];
                if (lookup_q.size() == 0)
                    report_mismatch(n_results, "unexpected result", m_tdata[31:0], '0);
                else
                begin
                    want = lookup_q[0];
                    lookup_q.delete(0);
                    if (got.hit !== want.hit)
                        report_mismatch(n_results, "hit", got.hit, want.hit);
                    if (got.slot !== want.slot)
                        report_mismatch(n_results, "slot", got.slot, want.slot);
                    if (got.allocated !== want.allocated)
                        report_mismatch(n_results, "allocated", got.allocated, want.allocated);
                    if (got.evicted !== want.evicted)
                        report_mismatch(n_results, "evicted", got.evicted, want.evicted);
                    if (got.ev.ring !== want.ev.ring)
                        report_mismatch(n_results, "evicted_ring", got.ev.ring, want.ev.ring);
                    if (got.ev.x !== want.ev.x)
                        report_mismatch(n_results, "evicted_x", got.ev.x, want.ev.x);
                    if (got.ev.z !== want.ev.z)
                        report_mismatch(n_results, "evicted_z", got.ev.z, want.ev.z);
                end
                n_results++;
            end
        end
    end

    task automatic push_req(input logic req_type, input logic [RING_W-1:0] ring,
                            input int x, input int z, input logic [FRAME_W-1:0] frame);
        tile_req_t rq;
        rq.req_type = req_type;
        rq.coord.ring = ring;
        rq.coord.x = x[COORD_W-1:0];
        rq.coord.z = z[COORD_W-1:0];
        rq.frame = frame;
        req_q.insert(req_q.size(), rq);
        n_queued++;
    endtask

    // wait until every queued item is taken and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (!(n_accepted == n_queued && lookup_q.size() == 0))
            @(negedge clk);
    endtask

    // register write with a setup and an access phase, only while idle
    task automatic write_slot_count(input logic [CNT_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= SLOT_COUNT_ADDR;
        pwdata <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        cfg_slot_count = value;
        n_settings++;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // coordinate with a bias toward the field extremes
    function automatic tile_coord_t random_coord();
        tile_coord_t c;
        c.ring = RING_W'($urandom_range(0, 7));
        c.x = COORD_W'($urandom);
        c.z = COORD_W'($urandom);
        case ($urandom_range(0, 7))
            0: c.x = 16'sh8000;
            1: c.x = 16'sh7FFF;
            2: c.z = 16'sh8000;
            3: c.z = 16'sh7FFF;
            default: ;
        endcase
        return c;
    endfunction

    // random items drawn mostly from the working set so that hits and evictions mix
    task automatic queue_random(input int count);
        tile_req_t rq;
        int k;
        int step;
        @(posedge clk);
        for (k = 0; k < count; k++)
        begin
            rq.req_type = ($urandom_range(0, 99) < 55) ? REQ_FILL : REQ_TOUCH;
            if ($urandom_range(0, 99) < 85)
                rq.coord = tile_pool[$urandom_range(0, tile_pool.size() - 1)];
            else
                rq.coord = random_coord();
            step = $urandom_range(0, 2);
            if (frame_now > FRAME_MAX - 32'(step))
                frame_now = $urandom_range(0, 1000);
            else
                frame_now += step;
            rq.frame = frame_now;
            if ($urandom_range(0, 9) == 0)
            begin
                rq.frame = $urandom;
                if (rq.frame > FRAME_MAX)
                    rq.frame = FRAME_MAX;
            end
            req_q.insert(req_q.size(), rq);
            n_queued++;
        end
    endtask

    // reset, directed items, then random phases over slot-count settings
    initial
    begin
        static logic [CNT_W-1:0] counts [12] = '{1, 0, 5, 127, 64, 2, 65, 17, 64, 8, 33, 3};
        int ph;
        int eff;
        int keep;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: miss on empty table, install, fill hit, touch hit, extremes
        @(posedge clk);
        push_req(REQ_TOUCH, 0, 0, 0, 0);
        push_req(REQ_FILL, 0, 0, 0, 0);
        push_req(REQ_FILL, 0, 0, 0, 7);
        push_req(REQ_TOUCH, 0, 0, 0, 5);
        push_req(REQ_FILL, 7, -32768, 32767, FRAME_MAX);
        push_req(REQ_FILL, 7, 32767, -32768, 1);
        push_req(REQ_TOUCH, 7, -32768, -32768, 9);
        push_req(REQ_TOUCH, 3, 0, 0, 9);
        push_req(REQ_FILL, 0, -1, -1, 2);
        push_req(REQ_TOUCH, 7, -32768, 32767, 3);
        wait_drained();

        // two slots: eviction with equal stamps, tile hidden above the count
        write_slot_count(2);
        @(posedge clk);
        push_req(REQ_FILL, 1, 100, 100, 10);
        push_req(REQ_FILL, 1, 200, 200, 10);
        push_req(REQ_FILL, 1, 300, 300, 10);
        push_req(REQ_TOUCH, 0, -1, -1, 11);
        push_req(REQ_FILL, 0, -1, -1, 11);
        wait_drained();

        // raised again: duplicate residents, lowest slot answers
        write_slot_count(SLOT_COUNT_RESET);
        @(posedge clk);
        push_req(REQ_TOUCH, 0, -1, -1, 12);
        push_req(REQ_FILL, 0, -1, -1, 13);
        push_req(REQ_TOUCH, 0, 0, 0, 14);
        frame_now = 20;

        for (ph = 0; ph < 12; ph++)
        begin
            wait_drained();
            write_slot_count(counts[ph]);
            eff = (counts[ph] == 0) ? 1 : (counts[ph] > SLOTS) ? SLOTS : counts[ph];
            ready_mode = (ph == 0) ? 0 : $urandom_range(0, 3);
            ready_pat = 16'($urandom) | 16'h0001;
            gaps_on = (ph != 0) && ($urandom_range(0, 3) != 0);
            if (ph == 4)
                frame_now = 32'hFFFF_FE00;
            // keep part of the old working set so hidden and stale tiles come back
            keep = tile_pool.size() / 3;
            while (tile_pool.size() > keep)
                tile_pool.delete($urandom_range(0, tile_pool.size() - 1));
            while (tile_pool.size() < eff + eff / 2 + 2)
                tile_pool.insert(tile_pool.size(), random_coord());
            queue_random(48);
            // hold off until the block has answered everything
            wait_drained();
            queue_random(48);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        while (lookup_q.size() != 0)
        begin
            lookup_q.delete(0);
            report_mismatch(n_results, "missing result", '0, '0);
        end
        $display("%0d requests checked over %0d slot-count writes", n_results, n_settings);
        $display("%0d hits, %0d installs, %0d evictions", n_hits, n_installs, n_evictions);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
